// ===== rtl/core/srt_pkg.sv =====
package srt_pkg;

  localparam int SRT_CAPACITY = 16;
  localparam int ADDR_MAX_W   = 10;

  localparam int KEY_W    = 31;
  localparam int SCORE_W  = 8;
  localparam int ACTION_W = 2;
  localparam int RDPOS_W  = 4;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EV,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_EV,
    S_SHF_RD,
    S_SHF_EV,
    S_READ_EV,
    S_POST
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] first;
    logic [SCORE_W-1:0] second;
    logic [SCORE_W-1:0] mean;
  } rec_t;

  // One read port and one write port on the record memory.
  typedef struct packed {
    logic                  rd_en;
    logic [ADDR_MAX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [ADDR_MAX_W-1:0] wr_addr;
    rec_t                  wr_data;
  } mem_req_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] entry_count;
    logic [POS_W-1:0]   touched_position;
    rec_t               rec;
  } out_item_t;

endpackage

// ===== rtl/core/srt_channels.sv =====
interface srt_in_if import srt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KEY_W-1:0]    record_key;
  logic [SCORE_W-1:0]  first_score;
  logic [SCORE_W-1:0]  second_score;
  logic [SCORE_W-1:0]  mean_score;
  logic [RDPOS_W-1:0]  read_position;

  modport source (output valid, action, record_key, first_score, second_score,
                  mean_score, read_position, input ready);
  modport sink   (input valid, action, record_key, first_score, second_score,
                  mean_score, read_position, output ready);
endinterface

interface srt_out_if import srt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [COUNT_W-1:0] entry_count;
  logic [POS_W-1:0]   touched_position;
  logic [KEY_W-1:0]   out_key;
  logic [SCORE_W-1:0] out_first_score;
  logic [SCORE_W-1:0] out_second_score;
  logic [SCORE_W-1:0] out_mean_score;

  modport source (output valid, status, entry_count, touched_position, out_key,
                  out_first_score, out_second_score, out_mean_score, input ready);
  modport sink   (input valid, status, entry_count, touched_position, out_key,
                  out_first_score, out_second_score, out_mean_score, output ready);
endinterface

// ===== rtl/core/srt_mem.sv =====
module srt_mem import srt_pkg::*; #(
  parameter int CAPACITY = SRT_CAPACITY
) (
  input  logic     clk,
  input  mem_req_t req,
  output rec_t     rd_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  rec_t mem [CAPACITY];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[IDX_W-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr[IDX_W-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/srt_ctrl.sv =====
module srt_ctrl import srt_pkg::*; #(
  parameter int CAPACITY = SRT_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  srt_in_if.sink           in_chan,
  srt_out_if.source        out_chan,
  output mem_req_t         req,
  input  rec_t             rd_data,
  output logic [CNT_W-1:0] count_o
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RW    = (CNT_W > RDPOS_W) ? CNT_W : RDPOS_W;
  localparam int EW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int PW    = (IDX_W > POS_W) ? IDX_W : POS_W;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  rec_t             new_rec_r, new_rec_nxt;
  out_item_t        res_r, res_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0] idx_inc, idx_dec, tpos;
  logic [CNT_W-1:0] cnt_dec;
  logic [RW-1:0]    rdpos_w, cnt_rw;
  logic             is_last, finish;

  function automatic logic [POS_W-1:0] pos_of(input logic [IDX_W-1:0] p);
    logic [PW-1:0] w;
    w = PW'(p);
    return w[POS_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
    logic [EW-1:0] w;
    w = EW'(c);
    return w[COUNT_W-1:0];
  endfunction

  assign idx_inc = idx_r + 1'b1;
  assign idx_dec = idx_r - 1'b1;
  assign cnt_dec = count_r - 1'b1;
  assign rdpos_w = RW'(in_chan.read_position);
  assign cnt_rw  = RW'(count_r);
  assign is_last = (CNT_W'(idx_r) + 1'b1) == count_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    new_rec_nxt = new_rec_r;
    res_nxt     = res_r;
    tpos        = '0;
    finish      = 1'b0;
    req         = '0;
    in_chan.ready = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          new_rec_nxt = '{key: in_chan.record_key, first: in_chan.first_score,
                          second: in_chan.second_score, mean: in_chan.mean_score};
          res_nxt.status = ST_EMPTY;
          res_nxt.rec    = '0;
          case (action_t'(in_chan.action))
            ACT_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_nxt.status = ST_FULL;
                finish = 1'b1;
              end else if (count_r == '0) begin
                req.wr_en   = 1'b1;
                req.wr_addr = '0;
                req.wr_data = new_rec_nxt;
                count_nxt   = CNT_W'(1);
                res_nxt.status = ST_DONE;
                res_nxt.rec    = new_rec_nxt;
                finish = 1'b1;
              end else begin
                idx_nxt   = cnt_dec[IDX_W-1:0];
                state_nxt = S_INS_RD;
              end
            end
            ACT_DELETE: begin
              if (count_r == '0) begin
                finish = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DEL_RD;
              end
            end
            ACT_READ: begin
              if (rdpos_w < cnt_rw) begin
                req.rd_en   = 1'b1;
                req.rd_addr = ADDR_MAX_W'(rdpos_w[IDX_W-1:0]);
                idx_nxt     = rdpos_w[IDX_W-1:0];
                state_nxt   = S_READ_EV;
              end else begin
                finish = 1'b1;
              end
            end
            default: finish = 1'b1;
          endcase
        end
      end

      S_INS_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = ADDR_MAX_W'(idx_r);
        state_nxt   = S_INS_EV;
      end

      S_INS_EV: begin
        req.wr_en   = 1'b1;
        req.wr_addr = ADDR_MAX_W'(idx_inc);
        if (rd_data.key >= new_rec_r.key) begin
          // Move the record up one place and keep walking down.
          req.wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_INS_WR;
          end else begin
            idx_nxt   = idx_dec;
            state_nxt = S_INS_RD;
          end
        end else begin
          req.wr_data    = new_rec_r;
          count_nxt      = count_r + 1'b1;
          res_nxt.status = ST_DONE;
          res_nxt.rec    = new_rec_r;
          tpos           = idx_inc;
          finish         = 1'b1;
        end
      end

      S_INS_WR: begin
        req.wr_en      = 1'b1;
        req.wr_addr    = '0;
        req.wr_data    = new_rec_r;
        count_nxt      = count_r + 1'b1;
        res_nxt.status = ST_DONE;
        res_nxt.rec    = new_rec_r;
        finish         = 1'b1;
      end

      S_DEL_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = ADDR_MAX_W'(idx_r);
        state_nxt   = S_DEL_EV;
      end

      S_DEL_EV: begin
        if (rd_data.key == new_rec_r.key) begin
          res_nxt.status = ST_DONE;
          res_nxt.rec    = rd_data;
          res_nxt.touched_position = pos_of(idx_r);
          if (is_last) begin
            count_nxt = cnt_dec;
            finish    = 1'b1;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_SHF_RD;
          end
        end else if (is_last) begin
          res_nxt.status = ST_NOT_FOUND;
          finish         = 1'b1;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_DEL_RD;
        end
      end

      S_SHF_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = ADDR_MAX_W'(idx_r);
        state_nxt   = S_SHF_EV;
      end

      S_SHF_EV: begin
        req.wr_en   = 1'b1;
        req.wr_addr = ADDR_MAX_W'(idx_dec);
        req.wr_data = rd_data;
        if (is_last) begin
          count_nxt = cnt_dec;
          finish    = 1'b1;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SHF_RD;
        end
      end

      S_READ_EV: begin
        res_nxt.status = ST_DONE;
        res_nxt.rec    = rd_data;
        tpos           = idx_r;
        finish         = 1'b1;
      end

      S_POST: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (finish) begin
      state_nxt = S_POST;
      res_nxt.entry_count = count_field(count_nxt);
      // A deleted record's position was captured when it was found.
      if (!(state_r == S_DEL_EV || state_r == S_SHF_EV) || res_nxt.status != ST_DONE) begin
        res_nxt.touched_position = pos_of(tpos);
      end
    end
  end

  // Output register: loads from the finished result once the slot is free.
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_POST && (!out_valid_r || out_chan.ready)) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r     <= idx_nxt;
    new_rec_r <= new_rec_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign count_o = count_r;

  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = out_r.status;
  assign out_chan.entry_count      = out_r.entry_count;
  assign out_chan.touched_position = out_r.touched_position;
  assign out_chan.out_key          = out_r.rec.key;
  assign out_chan.out_first_score  = out_r.rec.first;
  assign out_chan.out_second_score = out_r.rec.second;
  assign out_chan.out_mean_score   = out_r.rec.mean;

endmodule

// ===== rtl/core/sorted_record_table.sv =====
// Sorted record table.
// Records (31-bit key, two scores, an average) are held in ascending key
// order in a single-port-read, single-port-write memory of CAPACITY entries.
// The input channel carries one action per transfer: insert a record, delete
// the first record with a given key, or read the record at a position. Each
// transfer gives one result transfer: a status, the record count after the
// action, the position touched and the record inserted, deleted or read.
// Actions that touch stored records use a registered memory read followed
// by a compare, in a two-state read/evaluate loop. A read fetches the
// record at its position; a refused action or an insert into an empty
// table finishes without a read; an insert walks down from the last
// record, moving each record whose key is >= the new key up one place,
// then writes the new record; a delete scans up from position 0 to the
// first matching key, then shifts each later record down one place.
// One action is worked on at a time; the input is ready only while idle, so
// a new action is taken only after the last result is in the output register.
// The result sits in an output register, so a stalled receiver does not stop
// the next action from being taken and worked; only its result waits until
// the register is free. Reset clears the record count and all handshake
// state; the memory needs no clearing since only filled positions are read.
module sorted_record_table import srt_pkg::*; #(
  parameter int CAPACITY = SRT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  srt_in_if.sink    in_chan,
  srt_out_if.source out_chan
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  mem_req_t         mem_req;
  rec_t             mem_rd_data;
  logic [CNT_W-1:0] count;

  // Controller: sequencer for scan, shift, and the result/output registers.
  srt_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .req      (mem_req),
    .rd_data  (mem_rd_data),
    .count_o  (count)
  );

  // Record storage with registered read data.
  srt_mem #(
    .CAPACITY (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  // The table never holds more records than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  // Writes land inside the table.
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (mem_req.wr_addr < ADDR_MAX_W'(CAPACITY)))
    else $error("memory write beyond capacity");

  // The sequencer never reads and writes the same entry in one cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.rd_en && mem_req.wr_en && mem_req.rd_addr == mem_req.wr_addr))
    else $error("read and write to the same entry");

  // An accepted action keeps the input closed on the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input accepted while busy");

endmodule
